/* rtl/mm_pkg.sv */
// shared constants, types and helpers for the matrix multiply block
`default_nettype none

package mm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int DIM_W      = 4;
  localparam int SUM_W      = 35;
  localparam int PROD_W     = 2 * ELEM_WIDTH;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_ROWS = 3'd0,
    CFG_A_COLS = 3'd1,
    CFG_B_ROWS = 3'd2,
    CFG_B_COLS = 3'd3,
    CFG_A_TR   = 3'd4,
    CFG_B_TR   = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    MODE_A = 1'b0,
    MODE_B = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic clr_ij;
    logic step_ij;
    logic clr_k;
    logic issue;
    logic ld_out;
    logic ld_null;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mismatch;
    logic k_last;
    logic pipe_busy;
    logic out_last;
  } dp_status_t;

  // dimension register to (used dimension - 1)
  function automatic logic [IDX_W-1:0] dim_m1(input logic [DIM_W-1:0] r);
    logic [IDX_W-1:0] res;
    if (r == '0) begin
      res = '0;
    end else if (r > DIM_W'(MAX_DIM)) begin
      res = IDX_W'(MAX_DIM - 1);
    end else begin
      res = IDX_W'(r - DIM_W'(1));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/mm_ram.sv */
// generic single-write, single-read RAM with registered read data
`default_nettype none

module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/mm_ctrl.sv */
// controller state machine: load, multiply-accumulate sequencing, result beat
`default_nettype none

module mm_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_mode_i,
  input  wire logic               in_final_element_i,
  input  wire logic               out_ready_i,
  input  wire mm_pkg::dp_status_t status_i,
  output      logic               in_ready_o,
  output      logic               out_valid_o,
  output      mm_pkg::ctrl_cmd_t  cmd_o
);

  mm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      mm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if ((in_mode_i == mm_pkg::MODE_B) && in_final_element_i) begin
            if (status_i.mismatch) begin
              cmd_o.ld_null = 1'b1;
              state_d       = mm_pkg::ST_OUT;
            end else begin
              cmd_o.clr_ij = 1'b1;
              cmd_o.clr_k  = 1'b1;
              state_d      = mm_pkg::ST_CALC;
            end
          end
        end
      end
      mm_pkg::ST_CALC: begin
        cmd_o.issue = 1'b1;
        if (status_i.k_last) begin
          state_d = mm_pkg::ST_DRAIN;
        end
      end
      mm_pkg::ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          cmd_o.ld_out = 1'b1;
          state_d      = mm_pkg::ST_OUT;
        end
      end
      mm_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.out_last) begin
            state_d = mm_pkg::ST_IDLE;
          end else begin
            cmd_o.step_ij = 1'b1;
            cmd_o.clr_k   = 1'b1;
            state_d       = mm_pkg::ST_CALC;
          end
        end
      end
      default: begin
        state_d = mm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/mm_dp.sv */
// datapath: config registers, element stores, index counters, mac, result register
`default_nettype none

module mm_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  input  wire logic [mm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [mm_pkg::DIM_W-1:0]            cfg_data_i,
  input  wire logic                                in_mode_i,
  input  wire logic signed [mm_pkg::ELEM_WIDTH-1:0] in_element_i,
  input  wire logic                                in_final_element_i,
  input  wire mm_pkg::ctrl_cmd_t                   cmd_i,
  output      mm_pkg::dp_status_t                  status_o,
  output      logic signed [mm_pkg::SUM_W-1:0]     out_sum_o,
  output      logic [mm_pkg::IDX_W-1:0]            out_row_o,
  output      logic [mm_pkg::IDX_W-1:0]            out_col_o,
  output      logic                                out_null_result_o,
  output      logic                                out_last_o
);

  localparam int AW = mm_pkg::ADDR_W;
  localparam int IW = mm_pkg::IDX_W;

  logic [mm_pkg::DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic                     a_tr_q, b_tr_q;
  logic [mm_pkg::CNT_W-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [IW-1:0]            i_q, i_d, j_q, j_d, k_q, k_d;
  logic                     rd_v_q, p_v_q;
  logic signed [mm_pkg::PROD_W-1:0] prod_q;
  logic signed [mm_pkg::SUM_W-1:0]  acc_q, acc_d;
  logic [IW-1:0]            arm1, acm1, brm1, bcm1;
  logic [AW-1:0]            ar, ac, br, bc;
  logic [AW-1:0]            a_raddr, b_raddr;
  logic                     we_a, we_b;
  logic [mm_pkg::ELEM_WIDTH-1:0] rdata_a, rdata_b;
  logic                     i_last, j_last;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= mm_pkg::DIM_W'(1);
      a_cols_q <= mm_pkg::DIM_W'(1);
      b_rows_q <= mm_pkg::DIM_W'(1);
      b_cols_q <= mm_pkg::DIM_W'(1);
      a_tr_q   <= 1'b0;
      b_tr_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mm_pkg::CFG_A_ROWS: a_rows_q <= cfg_data_i;
        mm_pkg::CFG_A_COLS: a_cols_q <= cfg_data_i;
        mm_pkg::CFG_B_ROWS: b_rows_q <= cfg_data_i;
        mm_pkg::CFG_B_COLS: b_cols_q <= cfg_data_i;
        mm_pkg::CFG_A_TR:   a_tr_q   <= cfg_data_i[0];
        mm_pkg::CFG_B_TR:   b_tr_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign arm1 = mm_pkg::dim_m1(a_rows_q);
  assign acm1 = mm_pkg::dim_m1(a_cols_q);
  assign brm1 = mm_pkg::dim_m1(b_rows_q);
  assign bcm1 = mm_pkg::dim_m1(b_cols_q);
  assign ar   = AW'(arm1) + AW'(1);
  assign ac   = AW'(acm1) + AW'(1);
  assign br   = AW'(brm1) + AW'(1);
  assign bc   = AW'(bcm1) + AW'(1);

  // load counters, saturating at store depth
  assign we_a = cmd_i.accept && (in_mode_i == mm_pkg::MODE_A) &&
                (cnt_a_q < mm_pkg::CNT_W'(mm_pkg::DEPTH));
  assign we_b = cmd_i.accept && (in_mode_i == mm_pkg::MODE_B) &&
                (cnt_b_q < mm_pkg::CNT_W'(mm_pkg::DEPTH));

  always_comb begin
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    if (we_a) begin
      cnt_a_d = cnt_a_q + mm_pkg::CNT_W'(1);
    end
    if (we_b) begin
      cnt_b_d = cnt_b_q + mm_pkg::CNT_W'(1);
    end
    if (cmd_i.accept && (in_mode_i == mm_pkg::MODE_B) && in_final_element_i) begin
      cnt_a_d = '0;
      cnt_b_d = '0;
    end
  end

  // index counters
  assign i_last = (i_q == arm1);
  assign j_last = (j_q == bcm1);

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    if (cmd_i.clr_ij) begin
      i_d = '0;
      j_d = '0;
    end else if (cmd_i.step_ij) begin
      if (j_last) begin
        j_d = '0;
        i_d = i_q + IW'(1);
      end else begin
        j_d = j_q + IW'(1);
      end
    end
    if (cmd_i.clr_k) begin
      k_d = '0;
    end else if (cmd_i.issue) begin
      k_d = k_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      rd_v_q  <= 1'b0;
      p_v_q   <= 1'b0;
    end else begin
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      rd_v_q  <= cmd_i.issue;
      p_v_q   <= rd_v_q;
    end
  end

  // store addresses of logical (i, k) in A and (k, j) in B
  assign a_raddr = a_tr_q ? (AW'(k_q) * ar + AW'(i_q)) : (AW'(i_q) * ac + AW'(k_q));
  assign b_raddr = b_tr_q ? (AW'(j_q) * br + AW'(k_q)) : (AW'(k_q) * bc + AW'(j_q));

  mm_ram #(
    .WIDTH (mm_pkg::ELEM_WIDTH),
    .DEPTH (mm_pkg::DEPTH)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[AW-1:0]),
    .wdata_i (in_element_i),
    .raddr_i (a_raddr),
    .rdata_o (rdata_a)
  );

  mm_ram #(
    .WIDTH (mm_pkg::ELEM_WIDTH),
    .DEPTH (mm_pkg::DEPTH)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[AW-1:0]),
    .wdata_i (in_element_i),
    .raddr_i (b_raddr),
    .rdata_o (rdata_b)
  );

  // multiply, then accumulate
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.clr_k) begin
      acc_d = '0;
    end else if (p_v_q) begin
      acc_d = acc_q + mm_pkg::SUM_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(rdata_a) * $signed(rdata_b);
    acc_q  <= acc_d;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_null_result_o <= 1'b0;
      out_last_o        <= 1'b0;
    end else if (cmd_i.ld_null) begin
      out_null_result_o <= 1'b1;
      out_last_o        <= 1'b1;
    end else if (cmd_i.ld_out) begin
      out_null_result_o <= 1'b0;
      out_last_o        <= i_last && j_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_null) begin
      out_sum_o <= '0;
      out_row_o <= '0;
      out_col_o <= '0;
    end else if (cmd_i.ld_out) begin
      out_sum_o <= acc_q;
      out_row_o <= i_q;
      out_col_o <= j_q;
    end
  end

  assign status_o.mismatch  = (acm1 != brm1);
  assign status_o.k_last    = (k_q == acm1);
  assign status_o.pipe_busy = rd_v_q || p_v_q;
  assign status_o.out_last  = out_last_o;

endmodule

`default_nettype wire

/* rtl/matrix_multiply.sv */
// top level of the matrix multiply block: controller plus datapath
// loading: one cycle per element beat, in_ready high only while idle (no product running, no result pending)
// product: each result runs through the single shared mac
// (one store read per term, then multiply and accumulate stages), plus output handshake
// a dimension mismatch gives one null result beat on the cycle after the final element
// reset (async, active low): dimensions 1, no transpose, load counts zero; stores not cleared
`default_nettype none

module matrix_multiply (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  output      logic                                 cfg_ready_o,
  input  wire logic [mm_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [mm_pkg::DIM_W-1:0]             cfg_data_i,
  input  wire logic                                 in_valid_i,
  output      logic                                 in_ready_o,
  input  wire logic                                 in_mode_i,
  input  wire logic signed [mm_pkg::ELEM_WIDTH-1:0] in_element_i,
  input  wire logic                                 in_final_element_i,
  output      logic                                 out_valid_o,
  input  wire logic                                 out_ready_i,
  output      logic signed [mm_pkg::SUM_W-1:0]      out_sum_o,
  output      logic [mm_pkg::IDX_W-1:0]             out_row_o,
  output      logic [mm_pkg::IDX_W-1:0]             out_col_o,
  output      logic                                 out_null_result_o,
  output      logic                                 out_last_o
);

  mm_pkg::ctrl_cmd_t  cmd;
  mm_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  mm_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_mode_i          (in_mode_i),
    .in_final_element_i (in_final_element_i),
    .out_ready_i        (out_ready_i),
    .status_i           (status),
    .in_ready_o         (in_ready_o),
    .out_valid_o        (out_valid_o),
    .cmd_o              (cmd)
  );

  mm_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_mode_i          (in_mode_i),
    .in_element_i       (in_element_i),
    .in_final_element_i (in_final_element_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_sum_o          (out_sum_o),
    .out_row_o          (out_row_o),
    .out_col_o          (out_col_o),
    .out_null_result_o  (out_null_result_o),
    .out_last_o         (out_last_o)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input accepted while a result beat is pending");

  a_null_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_null_result_o) |-> (out_last_o && (out_sum_o == '0)))
    else $error("null result beat not last or nonzero");

  a_last_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_last_o) |=> in_ready_o)
    else $error("input not ready after last result beat");

  a_mismatch_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_mode_i && in_final_element_i && status.mismatch)
      |=> (out_valid_o && out_null_result_o))
    else $error("dimension mismatch did not give a null beat");

endmodule

`default_nettype wire
